// ----- src/t9pm_pkg.sv -----
package t9pm_pkg;

    // Digit buffer geometry, fixed by the packed field widths.
    localparam int NUM_DIGITS = 7;
    localparam int DIGIT_W    = 4;
    localparam int BUF_W      = NUM_DIGITS * DIGIT_W;
    localparam int LEN_W      = 3;
    localparam int IDX_W      = 9;
    localparam int COUNT_W    = 7;
    localparam int CFG_W      = 10;
    localparam int ENTRY_W    = BUF_W + LEN_W;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 7'h7F;

    // Request kinds carried in the input tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // Editing keys.
    localparam logic [3:0] KEY_DELETE = 4'd4;
    localparam logic [3:0] KEY_CLEAR  = 4'd8;

    typedef enum logic [1:0] {
        KIND_EMPTY   = 2'd0,
        KIND_EXACT   = 2'd1,
        KIND_PARTIAL = 2'd2,
        KIND_NONE    = 2'd3
    } match_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_FINISH,
        S_EMIT_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [DIGIT_W-1:0] digit;
    } key_digit_t;

    // Maps a keypad key to its T9 digit; keys without a digit give valid low.
    function automatic key_digit_t key_to_digit(input logic [3:0] key);
        key_digit_t r;
        r.valid = 1'b1;
        r.digit = key;
        case (key) inside
            4'd2, 4'd3:        r.digit = key;
            [4'd5:4'd7]:       r.digit = key - 4'd1;
            [4'd9:4'd11]:      r.digit = key - 4'd2;
            default:
            begin
                r.valid = 1'b0;
                r.digit = '0;
            end
        endcase
        return r;
    endfunction

    // Mask that keeps the lowest n digits of a packed buffer.
    function automatic logic [BUF_W-1:0] mask_digits(input logic [LEN_W-1:0] n);
        logic [BUF_W-1:0] m;
        m = '0;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if (j < int'(n))
            begin
                m[j*DIGIT_W +: DIGIT_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

// ----- src/t9pm_compare.sv -----
// Compares one table entry with the digit buffer: gives the length of the
// common prefix and whether the entry equals the buffer.
module t9pm_compare (
    input  logic [t9pm_pkg::BUF_W-1:0] entry_digits,
    input  logic [t9pm_pkg::LEN_W-1:0] entry_length,
    input  logic [t9pm_pkg::BUF_W-1:0] buf_digits,
    input  logic [t9pm_pkg::LEN_W-1:0] buf_length,
    output logic [t9pm_pkg::LEN_W-1:0] prefix,
    output logic                       exact
);

    logic [t9pm_pkg::NUM_DIGITS-1:0] digit_eq;
    logic [t9pm_pkg::LEN_W-1:0]      limit;

    // Per-digit equality, independent for each position.
    always_comb
    begin
        for (int j = 0; j < t9pm_pkg::NUM_DIGITS; j++)
        begin
            digit_eq[j] = entry_digits[j*t9pm_pkg::DIGIT_W +: t9pm_pkg::DIGIT_W] ==
                          buf_digits[j*t9pm_pkg::DIGIT_W +: t9pm_pkg::DIGIT_W];
        end
    end

    assign limit = (entry_length < buf_length) ? entry_length : buf_length;

    // Count the run of equal digits from the first one, up to the shorter length.
    always_comb
    begin
        logic run;
        run    = 1'b1;
        prefix = '0;
        for (int j = 0; j < t9pm_pkg::NUM_DIGITS; j++)
        begin
            if (run && digit_eq[j] && (j < int'(limit)))
            begin
                prefix = t9pm_pkg::LEN_W'(j + 1);
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    assign exact = (prefix == buf_length) && (entry_length == buf_length);

endmodule

// ----- src/t9_pinyin_digit_matcher.sv -----
// T9 digit matcher. Load beats (tuser low) write one key-table slot. A key beat
// (tuser high) edits the digit buffer and, unless the buffer is then empty,
// scans the first min(entry_count, TABLE_DEPTH) table entries through the table
// memory's one read port, one entry per cycle. Each exact-match beat after the
// first waits for a list read and for the output to be taken. Exact matches are
// given in table order, at most MAX_MATCHES beats, with tlast on the final one;
// otherwise one beat reports the empty buffer or the partial or missing match.
// The input is taken only between key events. Table slots hold no defined
// value until they are loaded; the table is not cleared.
module t9_pinyin_digit_matcher #(
    parameter int TABLE_DEPTH = 512,
    parameter int MAX_MATCHES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: entry_count.
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: key_code[3:0], entry_index[12:4], entry_digits[40:13],
    // entry_length[43:41], zero fill[47:44].
    input  logic [47:0] s_tdata,
    // Fields from bit 0: req_type[0].
    input  logic        s_tuser,
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: match_index[8:0], match_count[15:9], buffer_length[18:16],
    // buffer_digits[46:19], zero fill[47].
    output logic [47:0] m_tdata,
    // Fields from bit 0: match_kind[1:0].
    output logic [1:0]  m_tuser,
    // last_result.
    output logic        m_tlast
);

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_W  = (CNT_W > t9pm_pkg::CFG_W) ? CNT_W : t9pm_pkg::CFG_W;
    localparam int LIST_AW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;

    localparam int BUF_W   = t9pm_pkg::BUF_W;
    localparam int LEN_W   = t9pm_pkg::LEN_W;
    localparam int IDX_W   = t9pm_pkg::IDX_W;
    localparam int COUNT_W = t9pm_pkg::COUNT_W;

    // Input field unpacking.
    logic                      in_req;
    logic [3:0]                in_key;
    logic [IDX_W-1:0]          in_index;
    logic [BUF_W-1:0]          in_digits;
    logic [LEN_W-1:0]          in_length;
    logic                      in_accept;

    assign in_req    = s_tuser;
    assign in_key    = s_tdata[3:0];
    assign in_index  = s_tdata[12:4];
    assign in_digits = s_tdata[40:13];
    assign in_length = s_tdata[43:41];

    // Control registers.
    t9pm_pkg::state_t          state_reg, state_next;
    logic [t9pm_pkg::CFG_W-1:0] entry_count_reg;
    logic [BUF_W-1:0]          buf_digits_reg, buf_digits_next;
    logic [LEN_W-1:0]          buf_len_reg, buf_len_next;
    logic [SCAN_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]         pend_idx_reg, pend_idx_next;
    logic [COUNT_W-1:0]        hits_reg, hits_next;
    logic [LEN_W-1:0]          best_len_reg, best_len_next;
    logic [ADDR_W-1:0]         best_idx_reg, best_idx_next;
    logic [COUNT_W-1:0]        emit_ptr_reg, emit_ptr_next;
    logic                      out_valid_reg, out_valid_next;

    // Payload registers.
    t9pm_pkg::match_kind_t     res_kind_reg, res_kind_next;
    logic [IDX_W-1:0]          res_idx_reg, res_idx_next;
    logic [COUNT_W-1:0]        res_cnt_reg, res_cnt_next;
    t9pm_pkg::match_kind_t     out_kind_reg, out_kind_next;
    logic [IDX_W-1:0]          out_idx_reg, out_idx_next;
    logic [COUNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic [LEN_W-1:0]          out_len_reg, out_len_next;
    logic [BUF_W-1:0]          out_digits_reg, out_digits_next;
    logic                      out_last_reg, out_last_next;

    // Memories.
    logic [t9pm_pkg::ENTRY_W-1:0] tbl_mem [TABLE_DEPTH];
    logic [t9pm_pkg::ENTRY_W-1:0] tbl_q;
    logic [ADDR_W-1:0]            list_mem [MAX_MATCHES];
    logic [ADDR_W-1:0]            list_q;

    logic                      tbl_we;
    logic                      tbl_re;
    logic                      list_we;
    logic [SCAN_W-1:0]         scan_len;
    logic [COUNT_W-1:0]        list_n;
    logic                      out_free;
    logic [LEN_W-1:0]          cmp_prefix;
    logic                      cmp_exact;
    t9pm_pkg::key_digit_t      key_dig;
    logic [BUF_W-1:0]          edit_digits;
    logic [LEN_W-1:0]          edit_len;

    assign s_tready  = (state_reg == t9pm_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign scan_len = (SCAN_W'(entry_count_reg) > SCAN_W'(TABLE_DEPTH)) ?
                      SCAN_W'(TABLE_DEPTH) : SCAN_W'(entry_count_reg);
    assign list_n   = (hits_reg < COUNT_W'(MAX_MATCHES)) ? hits_reg : COUNT_W'(MAX_MATCHES);

    assign tbl_we  = in_accept && (in_req == t9pm_pkg::REQ_LOAD) &&
                     (32'(in_index) < TABLE_DEPTH);
    assign tbl_re  = (state_reg == t9pm_pkg::S_SCAN) && (rd_ptr_reg < scan_len);
    assign list_we = pend_valid_reg && cmp_exact && (hits_reg < COUNT_W'(MAX_MATCHES));

    // Key table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[ADDR_W'(in_index)] <= {in_length, in_digits};
        end
        tbl_q <= tbl_mem[rd_ptr_reg[ADDR_W-1:0]];
    end

    // Exact-match list, written during the scan and read while emitting.
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[hits_reg[LIST_AW-1:0]] <= pend_idx_reg;
        end
        list_q <= list_mem[emit_ptr_reg[LIST_AW-1:0]];
    end

    // Compare the entry read last cycle with the buffer.
    t9pm_compare u_compare (
        .entry_digits (tbl_q[BUF_W-1:0]),
        .entry_length (tbl_q[t9pm_pkg::ENTRY_W-1:BUF_W]),
        .buf_digits   (buf_digits_reg),
        .buf_length   (buf_len_reg),
        .prefix       (cmp_prefix),
        .exact        (cmp_exact)
    );

    // Buffer edit for an accepted key.
    always_comb
    begin
        key_dig     = t9pm_pkg::key_to_digit(in_key);
        edit_digits = buf_digits_reg;
        edit_len    = buf_len_reg;
        if (key_dig.valid)
        begin
            if (int'(buf_len_reg) < t9pm_pkg::NUM_DIGITS)
            begin
                edit_digits = buf_digits_reg |
                              (BUF_W'(key_dig.digit) << {buf_len_reg, 2'b00});
                edit_len    = buf_len_reg + LEN_W'(1);
            end
        end
        else if (in_key == t9pm_pkg::KEY_DELETE)
        begin
            edit_len    = (buf_len_reg != '0) ? buf_len_reg - LEN_W'(1) : '0;
            edit_digits = buf_digits_reg & t9pm_pkg::mask_digits(edit_len);
        end
        else if (in_key == t9pm_pkg::KEY_CLEAR)
        begin
            edit_len    = '0;
            edit_digits = '0;
        end
    end

    // Sequencer: next state, scan bookkeeping and result formation.
    always_comb
    begin
        state_next      = state_reg;
        buf_digits_next = buf_digits_reg;
        buf_len_next    = buf_len_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hits_next       = hits_reg;
        best_len_next   = best_len_reg;
        best_idx_next   = best_idx_reg;
        emit_ptr_next   = emit_ptr_reg;
        res_kind_next   = res_kind_reg;
        res_idx_next    = res_idx_reg;
        res_cnt_next    = res_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_cnt_next    = out_cnt_reg;
        out_len_next    = out_len_reg;
        out_digits_next = out_digits_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            t9pm_pkg::S_IDLE:
            begin
                if (in_accept && (in_req == t9pm_pkg::REQ_KEY))
                begin
                    buf_digits_next = edit_digits;
                    buf_len_next    = edit_len;
                    rd_ptr_next     = '0;
                    hits_next       = '0;
                    best_len_next   = '0;
                    best_idx_next   = '0;
                    if (edit_len == '0)
                    begin
                        res_kind_next = t9pm_pkg::KIND_EMPTY;
                        res_idx_next  = '0;
                        res_cnt_next  = '0;
                        state_next    = t9pm_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = t9pm_pkg::S_SCAN;
                    end
                end
            end

            t9pm_pkg::S_SCAN:
            begin
                // Issue the next read.
                if (tbl_re)
                begin
                    rd_ptr_next     = rd_ptr_reg + SCAN_W'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_ptr_reg[ADDR_W-1:0];
                end
                // Fold in the entry that arrived this cycle.
                if (pend_valid_reg)
                begin
                    if (cmp_exact)
                    begin
                        if (hits_reg != t9pm_pkg::COUNT_SAT)
                        begin
                            hits_next = hits_reg + COUNT_W'(1);
                        end
                    end
                    else if (cmp_prefix > best_len_reg)
                    begin
                        best_len_next = cmp_prefix;
                        best_idx_next = pend_idx_reg;
                    end
                end
                if (!tbl_re && !pend_valid_reg)
                begin
                    state_next = t9pm_pkg::S_RESOLVE;
                end
            end

            t9pm_pkg::S_RESOLVE:
            begin
                if (hits_reg != '0)
                begin
                    res_kind_next = t9pm_pkg::KIND_EXACT;
                    res_cnt_next  = hits_reg;
                    emit_ptr_next = '0;
                    state_next    = t9pm_pkg::S_EMIT_WAIT;
                end
                else if (best_len_reg != '0)
                begin
                    // Cut the buffer to the longest common prefix.
                    buf_len_next    = best_len_reg;
                    buf_digits_next = buf_digits_reg & t9pm_pkg::mask_digits(best_len_reg);
                    res_kind_next   = t9pm_pkg::KIND_PARTIAL;
                    res_idx_next    = IDX_W'(best_idx_reg);
                    res_cnt_next    = COUNT_W'(1);
                    state_next      = t9pm_pkg::S_FINISH;
                end
                else
                begin
                    // Nothing shares the first digit: drop the last one.
                    buf_len_next    = buf_len_reg - LEN_W'(1);
                    buf_digits_next = buf_digits_reg &
                                      t9pm_pkg::mask_digits(buf_len_reg - LEN_W'(1));
                    res_kind_next   = t9pm_pkg::KIND_NONE;
                    res_idx_next    = '0;
                    res_cnt_next    = '0;
                    state_next      = t9pm_pkg::S_FINISH;
                end
            end

            t9pm_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = res_kind_reg;
                    out_idx_next    = res_idx_reg;
                    out_cnt_next    = res_cnt_reg;
                    out_len_next    = buf_len_reg;
                    out_digits_next = buf_digits_reg;
                    out_last_next   = 1'b1;
                    state_next      = t9pm_pkg::S_IDLE;
                end
            end

            t9pm_pkg::S_EMIT_WAIT:
            begin
                // The list read for emit_ptr lands in list_q at this edge.
                state_next = t9pm_pkg::S_EMIT;
            end

            t9pm_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = t9pm_pkg::KIND_EXACT;
                    out_idx_next    = IDX_W'(list_q);
                    out_cnt_next    = res_cnt_reg;
                    out_len_next    = buf_len_reg;
                    out_digits_next = buf_digits_reg;
                    out_last_next   = (emit_ptr_reg + COUNT_W'(1)) == list_n;
                    if ((emit_ptr_reg + COUNT_W'(1)) == list_n)
                    begin
                        state_next = t9pm_pkg::S_IDLE;
                    end
                    else
                    begin
                        emit_ptr_next = emit_ptr_reg + COUNT_W'(1);
                        state_next    = t9pm_pkg::S_EMIT_WAIT;
                    end
                end
            end

            default:
            begin
                state_next = t9pm_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= t9pm_pkg::S_IDLE;
            entry_count_reg <= '0;
            buf_digits_reg  <= '0;
            buf_len_reg     <= '0;
            rd_ptr_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            hits_reg        <= '0;
            best_len_reg    <= '0;
            emit_ptr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end
            buf_digits_reg <= buf_digits_next;
            buf_len_reg    <= buf_len_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_valid_reg <= pend_valid_next;
            hits_reg       <= hits_next;
            best_len_reg   <= best_len_next;
            emit_ptr_reg   <= emit_ptr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        res_kind_reg   <= res_kind_next;
        res_idx_reg    <= res_idx_next;
        res_cnt_reg    <= res_cnt_next;
        out_kind_reg   <= out_kind_next;
        out_idx_reg    <= out_idx_next;
        out_cnt_reg    <= out_cnt_next;
        out_len_reg    <= out_len_next;
        out_digits_reg <= out_digits_next;
        out_last_reg   <= out_last_next;
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_digits_reg, out_len_reg, out_cnt_reg, out_idx_reg};

`ifndef SYNTHESIS
    // An exact-match beat always carries a nonzero match count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == t9pm_pkg::KIND_EXACT)) |-> (m_tdata[15:9] != '0))
        else $error("exact match beat with zero count");

    // An empty-buffer beat reports an empty buffer and no index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == t9pm_pkg::KIND_EMPTY)) |->
        ((m_tdata[18:16] == '0) && (m_tdata[8:0] == '0) && m_tlast))
        else $error("empty buffer beat with stale fields");

    // A partial match keeps at least one digit and counts one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == t9pm_pkg::KIND_PARTIAL)) |->
        ((m_tdata[18:16] != '0) && (m_tdata[15:9] == 7'd1) && m_tlast))
        else $error("partial match beat malformed");

    // The scan read pointer never runs past the scanned range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == t9pm_pkg::S_SCAN) |-> (rd_ptr_reg <= scan_len))
        else $error("scan pointer beyond entry count");

    // The match list is only written while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        list_we |-> (state_reg == t9pm_pkg::S_SCAN))
        else $error("match list written outside scan");
`endif

endmodule
